### src/cmdf_pkg.sv
// Shared types and constants of the cross median denoise filter.
package cmdf_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 4096;
   localparam int PIX_W        = 8;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(MAX_HEIGHT);
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int NUM_CELLS    = 3;
   localparam int FIFO_DEPTH   = 16;
   localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW      = FIFO_AW + 1;

   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [4:0] vec_type;

   typedef struct packed {
      pix_type pix;
      pix_type above;
      logic    has_first;
      logic    border;
      logic    last_row;
      logic    last_col;
   } side_type;

   typedef struct packed {
      pix_type pixel_out;
      logic    last_of_item;
      logic    end_of_frame;
   } rsp_type;

endpackage

### src/cmdf_req_if.sv
// Input channel: one pixel sample per item.
interface cmdf_req_if;
   logic                       valid;
   logic                       ready;
   logic [cmdf_pkg::PIX_W-1:0] pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink (input valid, input pixel_in, output ready);
endinterface

### src/cmdf_rsp_if.sv
// Result channel: one filtered pixel with its flags per item.
interface cmdf_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [cmdf_pkg::PIX_W-1:0] pixel_out;
   logic                       last_of_item;
   logic                       end_of_frame;

   modport source (output valid, output pixel_out, output last_of_item, output end_of_frame,
                   input ready);
   modport sink (input valid, input pixel_out, input last_of_item, input end_of_frame,
                 output ready);
endinterface

### src/cmdf_line_store.sv
// Two line stores holding the previous row and the row before it.
module cmdf_line_store (
   input  logic                        clock,
   input  logic [cmdf_pkg::COL_W-1:0]  rd_addr,
   output cmdf_pkg::pix_type           rd_above,
   output cmdf_pkg::pix_type           rd_right,
   output cmdf_pkg::pix_type           rd_two,
   input  logic                        wr_en,
   input  logic [cmdf_pkg::COL_W-1:0]  wr_addr,
   input  cmdf_pkg::pix_type           wr_above,
   input  cmdf_pkg::pix_type           wr_two
);
   import cmdf_pkg::*;

   pix_type                mem_above [MAX_WIDTH];
   pix_type                mem_two [MAX_WIDTH];
   pix_type                rd_above_ff;
   pix_type                rd_right_ff;
   pix_type                rd_two_ff;
   logic [COL_W-1:0]       right_addr;

   assign right_addr = rd_addr + COL_W'(1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_above[wr_addr] <= wr_above;
         mem_two[wr_addr]   <= wr_two;
      end
      rd_above_ff <= mem_above[rd_addr];
      rd_right_ff <= mem_above[right_addr];
      rd_two_ff   <= mem_two[rd_addr];
   end

   assign rd_above = rd_above_ff;
   assign rd_right = rd_right_ff;
   assign rd_two   = rd_two_ff;
endmodule

### src/cmdf_sort_cell.sv
// One sorting cell: two odd-even transposition layers over five samples.
module cmdf_sort_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                vld_in,
   input  cmdf_pkg::vec_type   vec_in,
   input  cmdf_pkg::side_type  side_in,
   output logic                vld_out,
   output cmdf_pkg::vec_type   vec_out,
   output cmdf_pkg::side_type  side_out
);
   import cmdf_pkg::*;

   logic     vld_ff;
   vec_type  vec_ff;
   vec_type  vec_in_sorted;
   side_type side_ff;

   always_comb begin
      vec_type a;
      vec_type b;
      a = vec_in;
      b = a;
      if (a[0] > a[1]) begin
         b[0] = a[1];
         b[1] = a[0];
      end
      if (a[2] > a[3]) begin
         b[2] = a[3];
         b[3] = a[2];
      end
      a = b;
      if (b[1] > b[2]) begin
         a[1] = b[2];
         a[2] = b[1];
      end
      if (b[3] > b[4]) begin
         a[3] = b[4];
         a[4] = b[3];
      end
      vec_in_sorted = a;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      vec_ff  <= vec_in_sorted;
      side_ff <= side_in;
   end

   assign vld_out  = vld_ff;
   assign vec_out  = vec_ff;
   assign side_out = side_ff;
endmodule

### src/cmdf_out_fifo.sv
// Result queue taking up to two items per cycle and giving one when the reader is ready.
module cmdf_out_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    wr_en,
   input  cmdf_pkg::rsp_type             wr_data0,
   input  cmdf_pkg::rsp_type             wr_data1,
   output logic                          rd_valid,
   input  logic                          rd_ready,
   output cmdf_pkg::rsp_type             rd_data,
   output logic [cmdf_pkg::FIFO_CW-1:0]  count
);
   import cmdf_pkg::*;

   rsp_type              store_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff;
   logic [FIFO_AW-1:0]   wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff;
   logic [FIFO_AW-1:0]   rd_ptr_in;
   logic [FIFO_CW-1:0]   count_ff;
   logic [FIFO_CW-1:0]   count_in;
   logic                 pop;
   logic [FIFO_AW-1:0]   wr_ptr_next;

   assign pop         = rd_valid && rd_ready;
   assign wr_ptr_next = wr_ptr_ff + FIFO_AW'(1);

   // Slot one is only used together with slot zero.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_AW'(wr_en[0]) + FIFO_AW'(wr_en[1]);
      rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
      count_in  = count_ff + FIFO_CW'(wr_en[0]) + FIFO_CW'(wr_en[1]) - FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (wr_en[0]) begin
         store_ff[wr_ptr_ff] <= wr_data0;
      end
      if (wr_en[1]) begin
         store_ff[wr_ptr_next] <= wr_data1;
      end
   end

   assign rd_valid = (count_ff != '0);
   assign rd_data  = store_ff[rd_ptr_ff];
   assign count    = count_ff;

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CW'(FIFO_DEPTH))
      else $error("result queue overflow");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      count_ff[FIFO_AW-1:0] == FIFO_AW'(wr_ptr_ff - rd_ptr_ff))
      else $error("result queue pointers disagree with count");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      wr_en[1] |-> wr_en[0])
      else $error("second slot written without the first");
`endif
endmodule

### src/cross_median_denoise_filter_unit.sv
// Top level of the cross-shaped five-point median filter.
// Throughput: one input item per cycle while the queue reservation allows it; a last-row item
// below row zero puts two results in the queue. A result passes the line-store read stage
// and then three sorting cells before it enters the queue, which registers it before rsp.
// Results run one image row behind the input. Reset is synchronous and clears counters,
// valid bits and the queue, and loads width 1024 and height 768; line stores are not cleared.
module cross_median_denoise_filter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   cmdf_req_if.sink                             req_ch,
   cmdf_rsp_if.source                           rsp_ch,
   input  logic                                 csr_we,
   input  cmdf_pkg::reg_index_type              csr_index,
   input  logic [cmdf_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import cmdf_pkg::*;

   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [WIDTH_REG_W-1:0]  width_eff;
   logic [HEIGHT_REG_W-1:0] height_eff;
   logic [WIDTH_REG_W-1:0]  width_m1;
   logic [HEIGHT_REG_W-1:0] height_m1;

   logic [COL_W-1:0]        col_ff;
   logic [COL_W-1:0]        col_in;
   logic [ROW_W-1:0]        row_ff;
   logic [ROW_W-1:0]        row_in;
   logic                    accept;
   logic                    last_col;
   logic                    last_row;

   logic                    s1_vld_ff;
   pix_type                 s1_pix_ff;
   logic [COL_W-1:0]        s1_col_ff;
   side_type                s1_side_ff;
   side_type                s1_side_in;
   logic                    s1_byp_ff;
   pix_type                 s1_byp_above_ff;
   pix_type                 s1_byp_two_ff;
   pix_type                 left_ff;

   pix_type                 rd_above;
   pix_type                 rd_right;
   pix_type                 rd_two;
   pix_type                 s1_above;
   pix_type                 s1_two;
   side_type                s1_side;

   logic                    cell_vld [NUM_CELLS+1];
   vec_type                 cell_vec [NUM_CELLS+1];
   side_type                cell_side [NUM_CELLS+1];

   logic [2:0]              inflight;
   logic [FIFO_CW:0]        reserved;
   logic [FIFO_CW-1:0]      fifo_count;
   logic [1:0]              q_wr_en;
   rsp_type                 q_data0;
   rsp_type                 q_data1;
   rsp_type                 res_first;
   rsp_type                 res_second;
   rsp_type                 q_head;
   side_type                done_side;
   pix_type                 median;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_REG_W'(MAX_WIDTH);
         height_ff <= HEIGHT_REG_W'(768);
      end else if (csr_we) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_ff  <= csr_wdata[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_wdata[HEIGHT_REG_W-1:0];
            default:          width_ff  <= width_ff;
         endcase
      end
   end

   // A size of zero counts as one; anything above the maximum saturates.
   always_comb begin
      if (width_ff == '0) begin
         width_eff = WIDTH_REG_W'(1);
      end else if (width_ff > WIDTH_REG_W'(MAX_WIDTH)) begin
         width_eff = WIDTH_REG_W'(MAX_WIDTH);
      end else begin
         width_eff = width_ff;
      end
      if (height_ff == '0) begin
         height_eff = HEIGHT_REG_W'(1);
      end else if (height_ff > HEIGHT_REG_W'(MAX_HEIGHT)) begin
         height_eff = HEIGHT_REG_W'(MAX_HEIGHT);
      end else begin
         height_eff = height_ff;
      end
      width_m1  = width_eff - WIDTH_REG_W'(1);
      height_m1 = height_eff - HEIGHT_REG_W'(1);
   end

   assign last_col = WIDTH_REG_W'(col_ff) >= width_m1;
   assign last_row = HEIGHT_REG_W'(row_ff) >= height_m1;

   // Items in flight each reserve two queue slots so that nothing ever stalls the pipeline.
   always_comb begin
      inflight = 3'(s1_vld_ff);
      for (int i = 1; i <= NUM_CELLS; i++) begin
         inflight = inflight + 3'(cell_vld[i]);
      end
      reserved = (FIFO_CW+1)'(fifo_count) + (FIFO_CW+1)'({inflight, 1'b0});
   end

   assign req_ch.ready = reserved <= (FIFO_CW+1)'(FIFO_DEPTH - 2);
   assign accept       = req_ch.valid && req_ch.ready;

   // Raster position counters.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      s1_side_in.pix       = req_ch.pixel_in;
      s1_side_in.above     = '0;
      s1_side_in.has_first = row_ff != '0;
      s1_side_in.border    = (row_ff == ROW_W'(1)) || (col_ff == '0) || last_col;
      s1_side_in.last_row  = last_row;
      s1_side_in.last_col  = last_col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         s1_vld_ff <= 1'b0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         s1_vld_ff <= accept;
      end
      s1_pix_ff  <= req_ch.pixel_in;
      s1_col_ff  <= col_ff;
      s1_side_ff <= s1_side_in;
      // A one-column frame reads the entry that the item ahead writes at this very edge.
      s1_byp_ff       <= s1_vld_ff && (s1_col_ff == col_ff);
      s1_byp_above_ff <= s1_pix_ff;
      s1_byp_two_ff   <= s1_above;
      if (s1_vld_ff) begin
         left_ff <= s1_above;
      end
   end

   cmdf_line_store u_line_store (
      .clock    (clock),
      .rd_addr  (col_ff),
      .rd_above (rd_above),
      .rd_right (rd_right),
      .rd_two   (rd_two),
      .wr_en    (s1_vld_ff),
      .wr_addr  (s1_col_ff),
      .wr_above (s1_pix_ff),
      .wr_two   (s1_above)
   );

   assign s1_above = s1_byp_ff ? s1_byp_above_ff : rd_above;
   assign s1_two   = s1_byp_ff ? s1_byp_two_ff : rd_two;

   always_comb begin
      s1_side       = s1_side_ff;
      s1_side.above = s1_above;
   end

   assign cell_vld[0]  = s1_vld_ff;
   assign cell_vec[0]  = {s1_pix_ff, s1_two, rd_right, left_ff, s1_above};
   assign cell_side[0] = s1_side;

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      cmdf_sort_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .vld_in   (cell_vld[g]),
         .vec_in   (cell_vec[g]),
         .side_in  (cell_side[g]),
         .vld_out  (cell_vld[g+1]),
         .vec_out  (cell_vec[g+1]),
         .side_out (cell_side[g+1])
      );
   end

   assign done_side = cell_side[NUM_CELLS];
   assign median    = cell_vec[NUM_CELLS][2];

   always_comb begin
      res_first.pixel_out     = done_side.border ? done_side.above : median;
      res_first.last_of_item  = !done_side.last_row;
      res_first.end_of_frame  = 1'b0;
      res_second.pixel_out    = done_side.pix;
      res_second.last_of_item = 1'b1;
      res_second.end_of_frame = done_side.last_col;
      q_wr_en = 2'b00;
      q_data0 = res_first;
      q_data1 = res_second;
      if (cell_vld[NUM_CELLS]) begin
         if (done_side.has_first) begin
            q_wr_en = done_side.last_row ? 2'b11 : 2'b01;
         end else if (done_side.last_row) begin
            q_wr_en = 2'b01;
            q_data0 = res_second;
         end
      end
   end

   cmdf_out_fifo u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_wr_en),
      .wr_data0 (q_data0),
      .wr_data1 (q_data1),
      .rd_valid (rsp_ch.valid),
      .rd_ready (rsp_ch.ready),
      .rd_data  (q_head),
      .count    (fifo_count)
   );

   assign rsp_ch.pixel_out    = q_head.pixel_out;
   assign rsp_ch.last_of_item = q_head.last_of_item;
   assign rsp_ch.end_of_frame = q_head.end_of_frame;

`ifndef ASSERT_OFF
   a_reserve_bound: assert property (@(posedge clock) disable iff (reset)
      reserved <= (FIFO_CW+1)'(FIFO_DEPTH))
      else $error("queue reservation exceeds its depth");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_vld_ff)
      else $error("accepted item did not enter the read stage");

   a_bypass_same_col: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && s1_byp_ff) |-> ($past(s1_col_ff) == s1_col_ff))
      else $error("bypass taken for a different column");
`endif
endmodule

### verif/tb.sv
// Testbench for the cross median filter: a self-checking pixel stream with a built-in predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cmdf_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned SETTLE_CYCLES = 10;
   localparam int unsigned RANDOM_ITEMS  = 1050;
   localparam int unsigned REPORT_LIMIT  = 10;
   localparam int unsigned LONG_ROW      = 256;

   logic clock;
   logic reset;
   logic csr_we;
   reg_index_type csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cmdf_req_if req_if ();
   cmdf_rsp_if rsp_if ();

   cross_median_denoise_filter_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the size registers and of the filter's line stores and counters.
   logic [WIDTH_REG_W-1:0]  width_reg;
   logic [HEIGHT_REG_W-1:0] height_reg;
   pix_type     line_above [MAX_WIDTH];
   pix_type     line_two_above [MAX_WIDTH];
   pix_type     left_above;
   int unsigned row_cnt;
   int unsigned col_cnt;

   pix_type     pixel_backlog [$];
   rsp_type     expected_px [$];
   int unsigned inputs_taken;
   int unsigned mismatches;
   int unsigned cycle_count;
   logic        req_taken;
   int unsigned hold_asks;
   int unsigned hold_seen;
   int unsigned hold_left;

   function automatic int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
   endfunction

   function automatic int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
   endfunction

   // Items still needed to close the current frame; valid only once the stream is drained.
   function automatic int unsigned items_to_frame_end();
      int unsigned w;
      int unsigned h;
      int unsigned c;
      w = eff_width();
      h = eff_height();
      c = col_cnt % MAX_WIDTH;
      return ((c >= w - 1) ? 1 : w - c) + ((row_cnt >= h - 1) ? 0 : (h - 1 - row_cnt) * w);
   endfunction

   // The sender backs off 8 percent of the time and the receiver 46 percent, then the
   // other way round, then neither.
   function automatic int unsigned send_gap_pct();
      if (inputs_taken < 350) return 8;
      if (inputs_taken < 700) return 46;
      return 0;
   endfunction

   function automatic int unsigned recv_gap_pct();
      if (inputs_taken < 350) return 46;
      if (inputs_taken < 700) return 8;
      return 0;
   endfunction

   task automatic filter_pixel(input pix_type pix);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      int unsigned i;
      int unsigned k;
      pix_type above;
      pix_type two;
      pix_type v;
      pix_type tmp;
      pix_type s [5];
      logic last_col;
      logic last_row;
      rsp_type res;
      w = eff_width();
      h = eff_height();
      c = col_cnt % MAX_WIDTH;
      r = row_cnt;
      above = line_above[c];
      two = line_two_above[c];
      last_col = (c >= w - 1);
      last_row = (r >= h - 1);
      if (r >= 1) begin
         if (r == 1 || c == 0 || last_col) begin
            v = above;
         end else begin
            s[0] = above;
            s[1] = left_above;
            s[2] = line_above[c + 1];
            s[3] = two;
            s[4] = pix;
            for (i = 0; i < 4; i++) begin
               for (k = 0; k < 4 - i; k++) begin
                  if (s[k] > s[k + 1]) begin
                     tmp = s[k];
                     s[k] = s[k + 1];
                     s[k + 1] = tmp;
                  end
               end
            end
            v = s[2];
         end
         res.pixel_out = v;
         res.last_of_item = !last_row;
         res.end_of_frame = 1'b0;
         expected_px.push_back(res);
      end
      // A pixel of the bottom row is a border pixel and follows its upper neighbour out.
      if (last_row) begin
         res.pixel_out = pix;
         res.last_of_item = 1'b1;
         res.end_of_frame = last_col;
         expected_px.push_back(res);
      end
      line_two_above[c] = above;
      line_above[c] = pix;
      left_above = above;
      if (last_col) begin
         col_cnt = 0;
         row_cnt = last_row ? 0 : r + 1;
      end else begin
         col_cnt = c + 1;
      end
   endtask

   function automatic pix_type pick_pixel(input int unsigned style, input pix_type base);
      int unsigned roll;
      int signed near;
      roll = $urandom_range(9);
      if (style == 0) return pix_type'($urandom_range(255));
      if (style == 2 || roll == 0) return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      if (roll == 1) return 8'hFF;
      near = int'(base) + int'($urandom_range(16)) - 8;
      if (near < 0) return 8'h00;
      if (near > 255) return 8'hFF;
      return pix_type'(near);
   endfunction

   task automatic push_items(input int unsigned count);
      int unsigned style;
      pix_type base;
      int unsigned n;
      style = $urandom_range(2);
      base = pix_type'($urandom_range(255));
      for (n = 0; n < count; n++) begin
         pixel_backlog.push_back(pick_pixel(style, base));
      end
   endtask

   task automatic wait_drained();
      while (pixel_backlog.size() != 0 || req_if.valid || expected_px.size() != 0) begin
         @(negedge clock);
      end
      // Row-0 items leave no result unless the frame is one row high, so let the pipeline run dry as well.
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input int unsigned value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      if (idx == REG_IMAGE_WIDTH) begin
         width_reg = value[WIDTH_REG_W-1:0];
      end else begin
         height_reg = value[HEIGHT_REG_W-1:0];
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic note_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display({"mismatch (%s) at cycle %0d: expected pix=%0d last=%0b eof=%0b,",
                   " got pix=%0d last=%0b eof=%0b"},
                  what, cycle_count, want.pixel_out, want.last_of_item, want.end_of_frame,
                  got.pixel_out, got.last_of_item, got.end_of_frame);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[cross_median_denoise_filter_unit] ERROR");
         $finish;
      end
   end

   // Input side: every accepted item goes through the predictor.
   always @(posedge clock) begin
      req_taken <= !reset && req_if.valid && req_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         inputs_taken++;
         filter_pixel(req_if.pixel_in);
      end
   end

   // Result side: each accepted result is checked against the oldest expectation.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.pixel_out = rsp_if.pixel_out;
         got.last_of_item = rsp_if.last_of_item;
         got.end_of_frame = rsp_if.end_of_frame;
         if (expected_px.size() == 0) begin
            want = '0;
            note_mismatch("no result expected", want, got);
         end else begin
            want = expected_px.pop_front();
            if (got.pixel_out !== want.pixel_out || got.last_of_item !== want.last_of_item ||
                got.end_of_frame !== want.end_of_frame) begin
               note_mismatch("wrong field", want, got);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_taken) pixel_backlog.delete(0);
         if (req_if.valid && !req_taken) begin
            // The current item has not been taken yet and must stay on offer.
         end else if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct()) begin
            req_if.valid <= 1'b1;
            req_if.pixel_in <= pixel_backlog[0];
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !reset && ($urandom_range(99) >= recv_gap_pct());
      end
   end

   initial begin
      int unsigned random_sent;
      int unsigned frame_n;
      int unsigned part;
      logic big_done;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = REG_IMAGE_WIDTH;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.pixel_in = '0;
      rsp_if.ready = 1'b0;
      req_taken = 1'b0;
      width_reg = 11'd1024;
      height_reg = 13'd768;
      left_above = '0;
      row_cnt = 0;
      col_cnt = 0;
      inputs_taken = 0;
      mismatches = 0;
      cycle_count = 0;
      hold_asks = 0;
      hold_seen = 0;
      hold_left = 0;
      random_sent = 0;
      big_done = 1'b0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         line_above[i] = '0;
         line_two_above[i] = '0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A 3x3 frame: eight border pixels and one true median in the centre.
      write_reg(REG_IMAGE_WIDTH, 3);
      write_reg(REG_IMAGE_HEIGHT, 3);
      pixel_backlog = '{8'h00, 8'hFF, 8'h00,
                        8'hC8, 8'h09, 8'h03,
                        8'hFF, 8'h00, 8'hFF};
      wait_drained();

      // Zero sizes count as one: every item is a frame of its own.
      write_reg(REG_IMAGE_WIDTH, 0);
      write_reg(REG_IMAGE_HEIGHT, 0);
      pixel_backlog.push_back(8'hFF);
      pixel_backlog.push_back(8'h00);
      wait_drained();

      // Oversized registers saturate; then both sizes shrink in the middle of the frame.
      write_reg(REG_IMAGE_WIDTH, 2047);
      write_reg(REG_IMAGE_HEIGHT, 8191);
      push_items(6);
      wait_drained();
      write_reg(REG_IMAGE_WIDTH, 3);
      push_items(4);
      wait_drained();
      write_reg(REG_IMAGE_HEIGHT, 3);
      push_items(items_to_frame_end());
      wait_drained();

      while (random_sent < RANDOM_ITEMS) begin
         if (!big_done && random_sent >= 500) begin
            // One long single-row frame; the receiver holds off meanwhile so the block backs up.
            wait_drained();
            write_reg(REG_IMAGE_WIDTH, LONG_ROW);
            write_reg(REG_IMAGE_HEIGHT, 1);
            push_items(LONG_ROW);
            hold_asks++;
            random_sent += LONG_ROW;
            big_done = 1'b1;
         end else begin
            if ($urandom_range(5) != 0) begin
               wait_drained();
               if ($urandom_range(3) != 0) begin
                  write_reg(REG_IMAGE_WIDTH,
                            ($urandom_range(11) == 0) ? $urandom_range(1) : $urandom_range(2, 12));
               end
               if ($urandom_range(3) != 0) begin
                  write_reg(REG_IMAGE_HEIGHT,
                            ($urandom_range(11) == 0) ? $urandom_range(1) : $urandom_range(2, 8));
               end
            end
            frame_n = eff_width() * eff_height();
            if (frame_n > 1 && $urandom_range(7) == 0) begin
               // A frame cut short or stretched by a size change while it is under way.
               part = $urandom_range(1, frame_n - 1);
               push_items(part);
               wait_drained();
               if ($urandom_range(1) != 0) begin
                  write_reg(REG_IMAGE_HEIGHT, $urandom_range(1, 8));
               end else begin
                  write_reg(REG_IMAGE_WIDTH, $urandom_range(1, eff_width()));
               end
               frame_n = items_to_frame_end();
               push_items(frame_n);
               random_sent += part + frame_n;
            end else begin
               push_items(frame_n);
               random_sent += frame_n;
            end
         end
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (mismatches == 0 && expected_px.size() == 0) begin
         $display("[cross_median_denoise_filter_unit] OK");
      end else begin
         $display("[cross_median_denoise_filter_unit] ERROR");
      end
      $finish;
   end

endmodule
